[rtl/sse_event_stream_parser_defines.svh]
// Assertion macros for the event-stream parser.
// Uses clk and rst of the module that expands them.
`ifndef SSE_EVENT_STREAM_PARSER_DEFINES_SVH
`define SSE_EVENT_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SSEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ssep_pkg.sv]
// Shared types, codes and character tables of the event-stream parser.
// No dependencies.
package ssep_pkg;

  localparam int LINE_LIMIT_DEF        = 2048;
  localparam int DATA_BUFFER_BYTES_DEF = 2048;

  localparam logic [1:0] OP_FEED    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic RES_DISPATCH = 1'b0;
  localparam logic RES_READ     = 1'b1;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_D     = 8'h64;
  localparam logic [7:0] CHAR_E     = 8'h65;

  typedef enum logic [2:0] {
    KIND_VALUES  = 3'd0,
    KIND_PATCHES = 3'd1,
    KIND_SYNC    = 3'd2,
    KIND_OTHER   = 3'd3,
    KIND_UNNAMED = 3'd4
  } kind_t;

  // Per-beat requests from the line parser to the buffer and result logic.
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_data;
    logic       disp;
    kind_t      kind;
  } evt_t;

  // Field prefix characters; a position past the end gives NUL, which never
  // reaches the prefix match.
  function automatic logic [7:0] ev_prefix_char(input logic [2:0] pos);
    case (pos)
      3'd0: ev_prefix_char = "e";
      3'd1: ev_prefix_char = "v";
      3'd2: ev_prefix_char = "e";
      3'd3: ev_prefix_char = "n";
      3'd4: ev_prefix_char = "t";
      3'd5: ev_prefix_char = ":";
      default: ev_prefix_char = CHAR_NUL;
    endcase
  endfunction

  function automatic logic [7:0] da_prefix_char(input logic [2:0] pos);
    case (pos)
      3'd0: da_prefix_char = "d";
      3'd1: da_prefix_char = "a";
      3'd2: da_prefix_char = "t";
      3'd3: da_prefix_char = "a";
      3'd4: da_prefix_char = ":";
      default: da_prefix_char = CHAR_NUL;
    endcase
  endfunction

  function automatic logic [7:0] values_char(input logic [2:0] pos);
    case (pos)
      3'd0: values_char = "v";
      3'd1: values_char = "a";
      3'd2: values_char = "l";
      3'd3: values_char = "u";
      3'd4: values_char = "e";
      3'd5: values_char = "s";
      default: values_char = CHAR_NUL;
    endcase
  endfunction

  function automatic logic [7:0] patches_char(input logic [2:0] pos);
    case (pos)
      3'd0: patches_char = "p";
      3'd1: patches_char = "a";
      3'd2: patches_char = "t";
      3'd3: patches_char = "c";
      3'd4: patches_char = "h";
      3'd5: patches_char = "e";
      3'd6: patches_char = "s";
      default: patches_char = CHAR_NUL;
    endcase
  endfunction

  function automatic logic [7:0] sync_char(input logic [2:0] pos);
    case (pos)
      3'd0: sync_char = "s";
      3'd1: sync_char = "y";
      3'd2: sync_char = "n";
      3'd3: sync_char = "c";
      default: sync_char = CHAR_NUL;
    endcase
  endfunction

  // Bit 0 values, bit 1 patches, bit 2 sync: which names still match here.
  function automatic logic [2:0] name_hits(input logic [2:0] pos, input logic [7:0] c);
    name_hits = {c == sync_char(pos), c == patches_char(pos), c == values_char(pos)};
  endfunction

endpackage

[rtl/ssep_line_core.sv]
// Line parser of the event-stream parser: line classes, event name match and
// data length bookkeeping. Depends on ssep_pkg.
module ssep_line_core #(
  parameter int LINE_LIMIT        = ssep_pkg::LINE_LIMIT_DEF,
  parameter int DATA_BUFFER_BYTES = ssep_pkg::DATA_BUFFER_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic                                 restart,
  input  logic [7:0]                           stream_byte,
  output ssep_pkg::evt_t                       evt,
  output logic [$clog2(DATA_BUFFER_BYTES)-1:0] wr_addr,
  output logic [$clog2(DATA_BUFFER_BYTES)-1:0] disp_len
);
  import ssep_pkg::*;

  localparam int AW  = $clog2(DATA_BUFFER_BYTES);
  localparam int TW  = $clog2(LINE_LIMIT + 1);
  localparam int LLW = $clog2(LINE_LIMIT);
  localparam int SW  = ((AW > TW) ? AW : TW) + 1;

  localparam logic [LLW-1:0] LINE_MAX = LLW'(LINE_LIMIT - 1);
  localparam logic [TW-1:0]  TENT_MAX = TW'(LINE_LIMIT);
  localparam logic [SW-1:0]  BUF_END  = SW'(DATA_BUFFER_BYTES);
  localparam logic [SW-1:0]  HELD_END = SW'(DATA_BUFFER_BYTES - 1);

  typedef enum logic [2:0] {
    CLS_START,
    CLS_IGNORE,
    CLS_PFX_EVENT,
    CLS_PFX_DATA,
    CLS_EV_SPACE,
    CLS_EV_NAME,
    CLS_DA_SPACE,
    CLS_DA_BODY
  } cls_t;

  logic [LLW-1:0] line_length, line_length_next;
  cls_t           line_class, line_class_next;
  logic [2:0]     prefix_position, prefix_position_next;
  logic [2:0]     name_flags, name_flags_next;
  logic [2:0]     name_length, name_length_next;
  logic [AW-1:0]  held, held_next;
  logic [TW-1:0]  tent, tent_next;
  logic           join_pend, join_pend_next;
  logic           content_ended, content_ended_next;
  kind_t          ev_kind, ev_kind_next;

  logic [SW-1:0] base_sum;
  logic [SW-1:0] body_sum;
  logic [SW-1:0] wr_sum;
  logic          wr_en_c;
  logic [7:0]    wr_data_c;
  logic          disp_c;
  logic [2:0]    hits;

  always_comb begin
    line_length_next     = line_length;
    line_class_next      = line_class;
    prefix_position_next = prefix_position;
    name_flags_next      = name_flags;
    name_length_next     = name_length;
    held_next            = held;
    tent_next            = tent;
    join_pend_next       = join_pend;
    content_ended_next   = content_ended;
    ev_kind_next         = ev_kind;

    // Next store position: after the held data, the pending newline and the
    // bytes of this line so far.
    base_sum  = SW'(held) + SW'(join_pend);
    body_sum  = base_sum + ((line_class == CLS_DA_BODY) ? SW'(tent) : '0);
    wr_sum    = body_sum;
    wr_en_c   = 1'b0;
    wr_data_c = stream_byte;
    disp_c    = 1'b0;
    hits      = name_hits(name_length, stream_byte);

    if (stream_byte == CHAR_CR) begin
      // Carriage returns are dropped without counting.
    end else if (stream_byte == CHAR_LF) begin
      case (line_class)
        CLS_START: begin
          if (held != '0) begin
            disp_c       = 1'b1;
            held_next    = '0;
            ev_kind_next = KIND_UNNAMED;
          end
        end
        CLS_EV_SPACE: begin
          ev_kind_next = KIND_UNNAMED;
        end
        CLS_EV_NAME: begin
          if (name_flags[0] && name_length == 3'd6) begin
            ev_kind_next = KIND_VALUES;
          end else if (name_flags[1] && name_length == 3'd7) begin
            ev_kind_next = KIND_PATCHES;
          end else if (name_flags[2] && name_length == 3'd4) begin
            ev_kind_next = KIND_SYNC;
          end else begin
            ev_kind_next = KIND_OTHER;
          end
        end
        CLS_DA_SPACE, CLS_DA_BODY: begin
          if (join_pend) begin
            wr_en_c   = 1'b1;
            wr_sum    = SW'(held);
            wr_data_c = CHAR_LF;
          end
          // A line that would overflow drops the whole event.
          if (body_sum < HELD_END) begin
            held_next = body_sum[AW-1:0];
          end else begin
            held_next    = '0;
            ev_kind_next = KIND_UNNAMED;
          end
        end
        default: begin
        end
      endcase
      line_length_next     = '0;
      line_class_next      = CLS_START;
      prefix_position_next = '0;
      name_flags_next      = '0;
      name_length_next     = '0;
      tent_next            = '0;
      join_pend_next       = 1'b0;
      content_ended_next   = 1'b0;
    end else if (line_length < LINE_MAX) begin
      line_length_next = line_length + 1'b1;
      if (!content_ended) begin
        if (stream_byte == CHAR_NUL) begin
          content_ended_next = 1'b1;
        end else begin
          case (line_class)
            CLS_START: begin
              if (stream_byte == CHAR_E) begin
                line_class_next      = CLS_PFX_EVENT;
                prefix_position_next = 3'd1;
              end else if (stream_byte == CHAR_D) begin
                line_class_next      = CLS_PFX_DATA;
                prefix_position_next = 3'd1;
              end else begin
                line_class_next = CLS_IGNORE;
              end
            end
            CLS_PFX_EVENT: begin
              if (prefix_position < 3'd6 &&
                  stream_byte == ev_prefix_char(prefix_position)) begin
                prefix_position_next = prefix_position + 3'd1;
                if (prefix_position == 3'd5) begin
                  line_class_next = CLS_EV_SPACE;
                end
              end else begin
                line_class_next = CLS_IGNORE;
              end
            end
            CLS_PFX_DATA: begin
              if (prefix_position < 3'd5 &&
                  stream_byte == da_prefix_char(prefix_position)) begin
                prefix_position_next = prefix_position + 3'd1;
                if (prefix_position == 3'd4) begin
                  line_class_next = CLS_DA_SPACE;
                  tent_next       = '0;
                  join_pend_next  = (held != '0) && ((SW'(held) + 1'b1) < HELD_END);
                end
              end else begin
                line_class_next = CLS_IGNORE;
              end
            end
            CLS_EV_SPACE: begin
              if (stream_byte != CHAR_SPACE) begin
                line_class_next  = CLS_EV_NAME;
                name_flags_next  = name_hits(3'd0, stream_byte);
                name_length_next = 3'd1;
              end
            end
            CLS_EV_NAME: begin
              name_flags_next = name_flags & hits;
              if (name_length != 3'd7) begin
                name_length_next = name_length + 3'd1;
              end
            end
            CLS_DA_SPACE: begin
              if (stream_byte != CHAR_SPACE) begin
                line_class_next = CLS_DA_BODY;
                wr_en_c         = body_sum < BUF_END;
                tent_next       = TW'(1);
              end
            end
            CLS_DA_BODY: begin
              wr_en_c = body_sum < BUF_END;
              if (tent < TENT_MAX) begin
                tent_next = tent + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      line_length     <= '0;
      line_class      <= CLS_START;
      prefix_position <= '0;
      name_flags      <= '0;
      name_length     <= '0;
      held            <= '0;
      tent            <= '0;
      join_pend       <= 1'b0;
      content_ended   <= 1'b0;
      ev_kind         <= KIND_UNNAMED;
    end else if (step) begin
      line_length     <= line_length_next;
      line_class      <= line_class_next;
      prefix_position <= prefix_position_next;
      name_flags      <= name_flags_next;
      name_length     <= name_length_next;
      held            <= held_next;
      tent            <= tent_next;
      join_pend       <= join_pend_next;
      content_ended   <= content_ended_next;
      ev_kind         <= ev_kind_next;
    end
  end

  assign evt.wr_en   = step && wr_en_c;
  assign evt.wr_data = wr_data_c;
  assign evt.disp    = step && disp_c;
  assign evt.kind    = ev_kind;
  assign wr_addr     = wr_sum[AW-1:0];
  assign disp_len    = held;

endmodule

[rtl/sse_event_stream_parser.sv]
// Event-stream parser top level: line parser, data buffer memory and result pipeline.
// Depends on ssep_pkg, ssep_line_core and sse_event_stream_parser_defines.svh.
// Pipeline: an accepted beat's result passes through the p_ registers, then the output registers.
// Throughput: one input beat per cycle while not stalled; one write, one read buffer port.
// Reset: rst clears all control state at once; the buffer memory is not cleared.
// A restart beat clears the line parser state and the shown length, and gives no result.
`include "sse_event_stream_parser_defines.svh"

module sse_event_stream_parser #(
  parameter int LINE_LIMIT        = ssep_pkg::LINE_LIMIT_DEF,
  parameter int DATA_BUFFER_BYTES = ssep_pkg::DATA_BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  stream_byte,
  input  logic [10:0] read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [2:0]  event_kind,
  output logic [10:0] data_length,
  output logic [7:0]  read_byte
);
  import ssep_pkg::*;

  localparam int AW = $clog2(DATA_BUFFER_BYTES);

  logic          accept;
  logic          do_read;
  evt_t          evt;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] disp_len;
  logic [AW-1:0] shown;
  logic [AW-1:0] rd_addr;
  logic [AW+10:0] ri_ext;
  logic [AW+10:0] len_ext;
  logic [AW-1:0] len_sel;

  logic [7:0] mem [DATA_BUFFER_BYTES];
  logic [7:0] mem_q;

  logic        p_vld;
  logic        p_rkind;
  kind_t       p_kind;
  logic [10:0] p_len;
  logic        p_hit;
  logic        p_move;
  logic        o_vld;

  assign p_move   = !o_vld || !out_stall;
  assign in_stall = p_vld && !p_move;
  assign accept   = in_valid && !in_stall;
  assign do_read  = accept && (op == OP_READ);

  ssep_line_core #(
    .LINE_LIMIT        (LINE_LIMIT),
    .DATA_BUFFER_BYTES (DATA_BUFFER_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (accept && (op == OP_FEED)),
    .restart     (accept && (op == OP_RESTART)),
    .stream_byte (stream_byte),
    .evt         (evt),
    .wr_addr     (wr_addr),
    .disp_len    (disp_len)
  );

  assign ri_ext  = {{AW{1'b0}}, read_index};
  assign rd_addr = ri_ext[AW-1:0];
  assign len_sel = evt.disp ? disp_len : shown;
  assign len_ext = {11'd0, len_sel};

  always_ff @(posedge clk) begin
    if (evt.wr_en) begin
      mem[wr_addr] <= evt.wr_data;
    end
    if (do_read) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Length of the last dispatched event, which bounds buffer reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      shown <= '0;
    end else if (accept && op == OP_RESTART) begin
      shown <= '0;
    end else if (evt.disp) begin
      shown <= disp_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (accept) begin
      p_vld <= evt.disp || do_read;
    end else if (p_move) begin
      p_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_rkind <= do_read ? RES_READ : RES_DISPATCH;
      // A read beat reports event kind zero.
      p_kind  <= do_read ? KIND_VALUES : evt.kind;
      p_len   <= len_ext[10:0];
      p_hit   <= do_read && (read_index < shown);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (p_move) begin
      o_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move && p_vld) begin
      result_kind <= p_rkind;
      event_kind  <= p_kind;
      data_length <= p_len;
      read_byte   <= p_hit ? mem_q : 8'd0;
    end
  end

  assign out_valid = o_vld;

  `SSEP_ASSERT_NOW(a_disp_no_byte, out_valid && result_kind == RES_DISPATCH, read_byte == 8'd0, "dispatch beat carries a buffer byte")
  `SSEP_ASSERT_NOW(a_read_no_kind, out_valid && result_kind == RES_READ, event_kind == KIND_VALUES, "read beat carries an event kind")
  `SSEP_ASSERT_NEXT(a_p_holds, p_vld && !p_move, p_vld && $stable(p_hit ? mem_q : 8'd0) && $stable(p_len), "held pipeline result changed while stalled")

endmodule
